// ===== rtl/core/acir_pkg.sv =====
// ----------------------------------------------------------------------------
// acir_pkg
// shared types and constants of the ir frame pulse encoder
// ----------------------------------------------------------------------------
package acir_pkg;

    localparam int POS_W = 9;

    // commands of an input word
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_NEXT = 1'b1;

    // configuration register indexes
    localparam logic REG_HEATING = 1'b0;
    localparam logic REG_COOLING = 1'b1;

    localparam logic [3:0] HEATING_RST = 4'd6;
    localparam logic [3:0] COOLING_RST = 4'd3;

    // frame positions
    localparam logic [POS_W-1:0] POS_WAKEUP = 9'd0;
    localparam logic [POS_W-1:0] POS_HEADER = 9'd1;
    localparam logic [POS_W-1:0] POS_TRAIL  = 9'd426;

    // pulse durations in microseconds, carrier on then carrier off
    localparam logic [14:0] WAKE_ON_US   = 15'd30000;
    localparam logic [15:0] WAKE_OFF_US  = 16'd49500;
    localparam logic [14:0] HDR_ON_US    = 15'd3380;
    localparam logic [15:0] HDR_OFF_US   = 16'd1700;
    localparam logic [14:0] DATA_ON_US   = 15'd530;
    localparam logic [15:0] ONE_OFF_US   = 16'd1100;
    localparam logic [15:0] ZERO_OFF_US  = 16'd300;
    localparam logic [15:0] TRAIL_OFF_US = 16'd0;

    // flag byte values
    localparam logic [7:0] FLAG_OFF      = 8'hE1;
    localparam logic [7:0] FLAG_HEATCOOL = 8'hF1;
    localparam logic [7:0] FLAG_OTHER    = 8'hF0;

    typedef struct packed {
        logic [5:0] temp;
        logic       power;
        logic [3:0] mode;
        logic [3:0] fan;
    } t_settings;

    typedef struct packed {
        logic [3:0] heating;
        logic [3:0] cooling;
    } t_cfg;

    typedef struct packed {
        logic [14:0] mark_us;
        logic [15:0] gap_us;
        logic        last;
    } t_pulse;

endpackage

// ===== rtl/core/acir_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// acir_cfg_regs
// apb register file holding the heating and cooling mode codes
// ----------------------------------------------------------------------------
module acir_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output acir_pkg::t_cfg   o_cfg
);
    import acir_pkg::*;

    t_cfg r_cfg;
    logic wr_en;
    logic reg_idx;

    assign reg_idx = paddr[2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.heating <= HEATING_RST;
            r_cfg.cooling <= COOLING_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_HEATING: r_cfg.heating <= pwdata[3:0];
                REG_COOLING: r_cfg.cooling <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_HEATING: prdata = {28'd0, r_cfg.heating};
            REG_COOLING: prdata = {28'd0, r_cfg.cooling};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/core/acir_pulse_lut.sv =====
// ----------------------------------------------------------------------------
// acir_pulse_lut
// pulse lookup by frame position, plus the following position
// ----------------------------------------------------------------------------
module acir_pulse_lut (
    input  logic [8:0]          i_pos,
    input  acir_pkg::t_settings i_set,
    input  acir_pkg::t_cfg      i_cfg,
    output acir_pkg::t_pulse    o_pulse,
    output logic [8:0]          o_next_pos
);
    import acir_pkg::*;

    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] bit_no;
    logic [5:0]       byte_no;
    logic [5:0]       k;
    logic [7:0]       raw;
    logic [7:0]       fbyte;
    logic [3:0]       nib;
    logic [7:0]       flag;

    // out-of-range positions restart at the wakeup
    assign pos    = (i_pos > POS_TRAIL) ? POS_WAKEUP : i_pos;
    assign bit_no = pos - 9'd2;
    assign byte_no = bit_no[8:3];
    assign k       = byte_no - 6'd3;

    assign nib = i_set.power ? i_set.mode : i_cfg.heating;

    always_comb begin
        if (!i_set.power) begin
            flag = FLAG_OFF;
        end else if (i_set.mode == i_cfg.heating || i_set.mode == i_cfg.cooling) begin
            flag = FLAG_HEATCOOL;
        end else begin
            flag = FLAG_OTHER;
        end
    end

    // raw byte table, variable entries for temperature, mode/fan and flag
    always_comb begin
        case (k[5:1])
            5'd0:  raw = 8'h40;
            5'd1:  raw = 8'hFF;
            5'd2:  raw = 8'hCC;
            5'd3:  raw = 8'h92;
            5'd4:  raw = 8'h13;
            5'd5:  raw = {i_set.temp, 2'b00};
            5'd11: raw = {i_set.fan, nib};
            5'd12: raw = flag;
            5'd15: raw = 8'h80;
            5'd16: raw = 8'h03;
            5'd17: raw = 8'h01;
            5'd18: raw = 8'h88;
            5'd21: raw = 8'hFF;
            5'd22: raw = 8'hFF;
            5'd23: raw = 8'hFF;
            5'd24: raw = 8'hFF;
            default: raw = 8'h00;
        endcase
    end

    // preamble, then each raw byte followed by its complement
    always_comb begin
        case (byte_no)
            6'd0: fbyte = 8'h01;
            6'd1: fbyte = 8'h10;
            6'd2: fbyte = 8'h00;
            default: begin
                if (byte_no >= 6'd53) begin
                    fbyte = 8'h00;
                end else if (k[0]) begin
                    fbyte = ~raw;
                end else begin
                    fbyte = raw;
                end
            end
        endcase
    end

    always_comb begin
        o_pulse.last = 1'b0;
        if (pos == POS_WAKEUP) begin
            o_pulse.mark_us = WAKE_ON_US;
            o_pulse.gap_us  = WAKE_OFF_US;
        end else if (pos == POS_HEADER) begin
            o_pulse.mark_us = HDR_ON_US;
            o_pulse.gap_us  = HDR_OFF_US;
        end else if (pos == POS_TRAIL) begin
            o_pulse.mark_us = DATA_ON_US;
            o_pulse.gap_us  = TRAIL_OFF_US;
            o_pulse.last    = 1'b1;
        end else begin
            o_pulse.mark_us = DATA_ON_US;
            o_pulse.gap_us  = fbyte[bit_no[2:0]] ? ONE_OFF_US : ZERO_OFF_US;
        end
    end

    assign o_next_pos = (pos == POS_TRAIL) ? POS_WAKEUP : pos + 9'd1;

endmodule

// ===== rtl/core/ac_ir_frame_pulse_encoder.sv =====
// ----------------------------------------------------------------------------
// ac_ir_frame_pulse_encoder
// air-conditioner ir command encoder, one mark/space pulse per next word
// ----------------------------------------------------------------------------
// latency: a next word passes the input register, then the lookup, into the result register
// throughput: one word per cycle, loads and nexts alike, while no next waits on a full result register
// the rate is set by the input register, the combinational lookup and the result register
// reset: synchronous active low; clears settings, frame position and both
// valid flags, and loads the mode code registers with heating 6, cooling 3
// ----------------------------------------------------------------------------
module ac_ir_frame_pulse_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input word channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [5:0]  i_temp_c,
    input  logic        i_power_on,
    input  logic [3:0]  i_mode,
    input  logic [3:0]  i_fan,
    // result word channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [14:0] o_mark_us,
    output logic [15:0] o_space_us,
    output logic        o_last
);
    import acir_pkg::*;

    // input register stage
    logic             r_in_valid;
    logic             r_in_cmd;
    t_settings        r_in_set;

    // held settings and frame position
    t_settings        r_held;
    logic [POS_W-1:0] r_pos;

    // result register stage
    logic             r_out_valid;
    t_pulse           r_out;

    t_cfg             cfg;
    t_pulse           pulse;
    logic [POS_W-1:0] next_pos;
    logic             advance;
    logic             in_fire;

    acir_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    acir_pulse_lut u_lut (
        .i_pos      (r_pos),
        .i_set      (r_held),
        .i_cfg      (cfg),
        .o_pulse    (pulse),
        .o_next_pos (next_pos)
    );

    // a load never needs the result register, a next needs it free or draining
    assign advance    = r_in_valid & ((r_in_cmd == CMD_LOAD) | ~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | advance;
    assign in_fire    = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // payload of the input stage, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_cmd       <= i_cmd;
            r_in_set.temp  <= i_temp_c;
            r_in_set.power <= i_power_on;
            r_in_set.mode  <= i_mode;
            r_in_set.fan   <= i_fan;
        end
    end

    // a load latches settings and restarts the frame, a next steps it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_pos  <= POS_WAKEUP;
        end else if (advance) begin
            if (r_in_cmd == CMD_LOAD) begin
                r_held <= r_in_set;
                r_pos  <= POS_WAKEUP;
            end else begin
                r_pos  <= next_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_cmd == CMD_NEXT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_cmd == CMD_NEXT) begin
            r_out <= pulse;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_mark_us   = r_out.mark_us;
    assign o_space_us  = r_out.gap_us;
    assign o_last      = r_out.last;

endmodule
